// ===== rtl/http_request_framer_assert.svh =====
// Assertion macros shared by the framer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef HTTP_REQUEST_FRAMER_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

// ===== rtl/hrf_pkg.sv =====
// Types, constants and helper functions of the HTTP request framer.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package hrf_pkg;

	localparam int CONNECTIONS = 8;
	localparam int LENGTH_BITS = 32;
	localparam int CONN_W = 3;
	localparam int PREFIX_LEN = 16;
	localparam int POS_W = $clog2(PREFIX_LEN + 1);
	localparam logic [8*PREFIX_LEN-1:0] LENGTH_PREFIX = "Content-Length: ";
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;

	typedef enum logic [1:0] {
		CLS_LINE_BYTE = 2'd0,
		CLS_LINE_END  = 2'd1,
		CLS_BLOCK_END = 2'd2,
		CLS_BODY      = 2'd3
	} cls_t;

	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic                   in_body;
		logic                   cr_held;
		logic [POS_W-1:0]       line_pos;
		logic                   prefix_match;
		phase_t                 num_phase;
		logic                   num_negative;
		logic [LENGTH_BITS-1:0] num_value;
		logic [LENGTH_BITS-1:0] bytes_left;
	} slot_t;

	typedef struct packed {
		logic              kind;
		logic [CONN_W-1:0] connection;
		logic [7:0]        data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [CONN_W-1:0] connection_out;
		logic [7:0]        byte_out;
		cls_t              item_class;
		logic              request_done;
		logic              last;
	} res_t;

	localparam slot_t SLOT_CLEAR = '{
		in_body: 1'b0, cr_held: 1'b0, line_pos: '0, prefix_match: 1'b1,
		num_phase: PH_SKIP, num_negative: 1'b0, num_value: '0, bytes_left: '0
	};

	function automatic slot_t clear_line(slot_t s);
		slot_t r;
		r = s;
		r.line_pos = '0;
		r.prefix_match = 1'b1;
		r.num_phase = PH_SKIP;
		r.num_negative = 1'b0;
		r.num_value = '0;
		return r;
	endfunction

	function automatic logic [7:0] prefix_char(logic [POS_W-2:0] p);
		return LENGTH_PREFIX[(PREFIX_LEN - 1 - int'(p)) * 8 +: 8];
	endfunction

	// One step of a base-10 strtoul-style parse; overflow saturates to all ones.
	function automatic slot_t parse_byte(slot_t s, logic [7:0] b);
		slot_t r;
		logic digit;
		logic ws;
		logic [3:0] d;
		logic [LENGTH_BITS+3:0] prod;
		r = s;
		digit = b inside {["0":"9"]};
		ws = (b == " ") || (b inside {[8'd9:8'd13]});
		d = b[3:0];
		prod = ({4'b0, s.num_value} << 3) + ({4'b0, s.num_value} << 1)
			+ (LENGTH_BITS+4)'(d);
		case (s.num_phase)
			PH_SKIP, PH_SIGN: begin
				if (s.num_phase == PH_SKIP && ws) begin
					r = s;
				end else if (s.num_phase == PH_SKIP && (b == "+" || b == "-")) begin
					r.num_negative = (b == "-");
					r.num_phase = PH_SIGN;
				end else if (digit) begin
					r.num_value = LENGTH_BITS'(d);
					r.num_phase = PH_DIGITS;
				end else begin
					r.num_value = '0;
					r.num_negative = 1'b0;
					r.num_phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (!digit) begin
					r.num_phase = PH_DONE;
				end else if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
					r.num_value = '1;
					r.num_negative = 1'b0;
					r.num_phase = PH_DONE;
				end else begin
					r.num_value = prod[LENGTH_BITS-1:0];
				end
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	// A header line byte: match the length prefix, then feed the parser.
	function automatic slot_t line_byte(slot_t s, logic [7:0] b);
		slot_t r;
		r = s;
		if (s.line_pos < POS_W'(PREFIX_LEN)) begin
			if (s.prefix_match && b != prefix_char(s.line_pos[POS_W-2:0])) begin
				r.prefix_match = 1'b0;
			end
			r.line_pos = s.line_pos + POS_W'(1);
		end else if (s.prefix_match) begin
			r = parse_byte(s, b);
		end
		return r;
	endfunction

endpackage

// ===== rtl/hrf_in_if.sv =====
// Input channel of the framer: received bytes and connection events.
// Depends on hrf_pkg.
`timescale 1ns / 1ps

interface hrf_in_if import hrf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [CONN_W-1:0] connection;
	logic [7:0]        data_byte;
	logic              chunk_last;

	modport source (output valid, kind, connection, data_byte, chunk_last, input ready);
	modport sink (input valid, kind, connection, data_byte, chunk_last, output ready);
endinterface

// ===== rtl/hrf_out_if.sv =====
// Output channel of the framer: framed header and body items.
// Depends on hrf_pkg.
`timescale 1ns / 1ps

interface hrf_out_if import hrf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CONN_W-1:0] connection_out;
	logic [7:0]        byte_out;
	logic [1:0]        item_class;
	logic              request_done;
	logic              last;

	modport source (output valid, connection_out, byte_out, item_class, request_done, last,
		input ready);
	modport sink (input valid, connection_out, byte_out, item_class, request_done, last,
		output ready);
endinterface

// ===== rtl/http_request_framer.sv =====
// HTTP/1.1 request framer with per-connection header and Content-Length state.
// Depends on hrf_pkg, hrf_in_if, hrf_out_if and http_request_framer_assert.svh.
//
// The rx channel takes one beat per received byte or per connection event,
// tagged with its connection slot. The tx channel gives framed items: header
// line bytes, line end marks, header block end marks and body bytes, each
// with a request done flag and a last flag for the final item of one rx beat.
// An rx beat lands in an input register; from there it is framed against the
// slot state, which is updated, and its results are written to a two-entry
// result register, from which tx is driven. One rx beat is taken every cycle
// while tx is not stalled and each beat gives at most one item.
// A beat that gives two items (a held CR followed by another byte) holds the
// result register for two tx beats, so the rate there is set by the tx port.
// When tx stalls, one more rx beat is held in the input register and rx
// ready then drops until the result register drains.
// Reset clears all slot state at once; no sweep is needed. An open or close
// event clears its slot and gives no item.
`timescale 1ns / 1ps
`include "http_request_framer_assert.svh"

module http_request_framer import hrf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	hrf_in_if.sink    rx,
	hrf_out_if.source tx
);

	in_beat_t   in_s1;
	logic       in_valid_s1;
	slot_t      slots_q [CONNECTIONS];
	res_t       res0_q;
	res_t       res1_q;
	logic [1:0] res_cnt_q;

	slot_t      cur;
	slot_t      nxt;
	slot_t      tmp;
	res_t       r0;
	res_t       r1;
	logic [1:0] nres;
	logic       in_range;
	logic       res_free;
	logic       advance;
	logic       pop;
	logic       done;
	logic       blk;
	logic [LENGTH_BITS-1:0] left;

	assign pop = tx.valid && tx.ready;
	assign res_free = (res_cnt_q == 2'd0) || (res_cnt_q == 2'd1 && tx.ready);
	assign advance = in_valid_s1 && (nres == 2'd0 || res_free);
	assign rx.ready = !in_valid_s1 || advance;
	assign in_range = {1'b0, in_s1.connection} < (CONN_W+1)'(CONNECTIONS);

	always_comb begin
		cur = slots_q[in_s1.connection];
		nxt = cur;
		tmp = cur;
		nres = 2'd0;
		done = 1'b0;
		blk = 1'b0;
		left = cur.bytes_left;
		r0 = '{connection_out: in_s1.connection, byte_out: in_s1.data_byte,
			item_class: CLS_LINE_BYTE, request_done: 1'b0, last: 1'b1};
		r1 = r0;
		if (!in_range) begin
			nres = 2'd0;
		end else if (in_s1.kind) begin
			nxt = SLOT_CLEAR;
		end else if (cur.in_body) begin
			if (left != '0) begin
				left = left - LENGTH_BITS'(1);
			end
			done = (left == '0);
			nxt.bytes_left = left;
			if (done) begin
				nxt.in_body = 1'b0;
			end
			r0.item_class = CLS_BODY;
			r0.request_done = done;
			nres = 2'd1;
		end else if (cur.cr_held) begin
			if (in_s1.data_byte == CH_LF) begin
				nxt.cr_held = 1'b0;
				if (cur.line_pos == '0) begin
					blk = 1'b1;
					if (cur.bytes_left != '0) begin
						nxt.in_body = 1'b1;
					end else begin
						done = 1'b1;
					end
				end else if (cur.prefix_match && cur.line_pos >= POS_W'(PREFIX_LEN)) begin
					nxt.bytes_left = cur.num_negative ? (LENGTH_BITS'(0) - cur.num_value)
						: cur.num_value;
				end
				nxt = clear_line(nxt);
				r0.byte_out = 8'h00;
				r0.item_class = blk ? CLS_BLOCK_END : CLS_LINE_END;
				r0.request_done = done;
				nres = 2'd1;
			end else if (in_s1.data_byte == CH_CR) begin
				nxt = line_byte(cur, CH_CR);
				r0.byte_out = CH_CR;
				nres = 2'd1;
			end else begin
				tmp = line_byte(cur, CH_CR);
				nxt = line_byte(tmp, in_s1.data_byte);
				nxt.cr_held = 1'b0;
				r0.byte_out = CH_CR;
				r0.last = 1'b0;
				nres = 2'd2;
			end
		end else if (in_s1.data_byte == CH_CR) begin
			nxt.cr_held = 1'b1;
		end else begin
			nxt = line_byte(cur, in_s1.data_byte);
			nres = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			in_s1 <= '{kind: rx.kind, connection: rx.connection, data_byte: rx.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONNECTIONS; i++) begin
				slots_q[i] <= SLOT_CLEAR;
			end
		end else if (advance && in_range) begin
			slots_q[in_s1.connection] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else if (advance && nres != 2'd0) begin
			res_cnt_q <= nres;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && nres != 2'd0) begin
			res0_q <= r0;
			res1_q <= r1;
		end else if (pop && res_cnt_q == 2'd2) begin
			res0_q <= res1_q;
		end
	end

	assign tx.valid = (res_cnt_q != 2'd0);
	assign tx.connection_out = res0_q.connection_out;
	assign tx.byte_out = res0_q.byte_out;
	assign tx.item_class = res0_q.item_class;
	assign tx.request_done = res0_q.request_done;
	assign tx.last = res0_q.last;

	`HRF_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, res_cnt_q != 2'd3)
	`HRF_ASSERT_NOW(a_pair_first_not_last, clk, arst_n, res_cnt_q == 2'd2, !res0_q.last)
	`HRF_ASSERT_NEXT(a_pair_drains, clk, arst_n, res_cnt_q == 2'd2 && pop, res_cnt_q == 2'd1)
	`HRF_ASSERT_NOW(a_body_no_cr, clk, arst_n, in_valid_s1 && cur.in_body, !cur.cr_held)
	`HRF_ASSERT_NOW(a_pos_bound, clk, arst_n, in_valid_s1,
		cur.line_pos <= POS_W'(PREFIX_LEN))

endmodule

// ===== tb/http_request_framer_tb.sv =====
// Self-checking HTTP request framer testbench: directed beats, then random requests,
// noise and broken ones over all connections, checked against a framing predictor.
// Depends on hrf_pkg, hrf_in_if, hrf_out_if and http_request_framer.
`timescale 1ns / 1ps

module http_request_framer_tb;
	import hrf_pkg::*;

	typedef struct packed {
		bit              pause;
		bit              kind;
		bit [CONN_W-1:0] conn;
		bit [7:0]        data;
		bit              chunk_last;
	} rx_beat_t;

	typedef struct packed {
		bit [CONN_W-1:0] conn;
		bit [7:0]        data;
		cls_t            cls;
		bit              done;
		bit              last;
	} framed_item_t;

	typedef struct {
		bit                   in_body;
		bit                   cr_held;
		int unsigned          line_pos;
		bit                   prefix_ok;
		phase_t               phase;
		bit                   negative;
		bit [LENGTH_BITS-1:0] value;
		bit [LENGTH_BITS-1:0] remaining;
	} conn_frame_t;

	logic clk;
	logic arst_n;

	hrf_in_if  rx_if ();
	hrf_out_if tx_if ();

	http_request_framer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	conn_frame_t  frames[CONNECTIONS];
	framed_item_t framed_q[$];
	rx_beat_t     stim_q[$];
	bit [8:0]     streams[CONNECTIONS][$];

	int errors = 0;
	int beats_taken = 0;
	int events_taken = 0;
	int requests_built = 0;
	int pauses_done = 0;
	int done_count = 0;
	int seen_cls[4] = '{0, 0, 0, 0};
	int gap_left;
	int burst_left;
	int ready_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Framing predictor.

	function automatic void restart_line(int c);
		frames[c].line_pos = 0;
		frames[c].prefix_ok = 1'b1;
		frames[c].phase = PH_SKIP;
		frames[c].negative = 1'b0;
		frames[c].value = '0;
	endfunction

	function automatic void clear_conn(int c);
		frames[c].in_body = 1'b0;
		frames[c].cr_held = 1'b0;
		frames[c].remaining = '0;
		restart_line(c);
	endfunction

	function automatic void scan_length(int c, bit [7:0] b);
		bit is_digit;
		bit is_space;
		bit [LENGTH_BITS+3:0] grown;
		is_digit = (b >= "0") && (b <= "9");
		is_space = (b == " ") || (b >= 8'd9 && b <= 8'd13);
		grown = {4'd0, frames[c].value} * 10 + (b - 8'd48);
		if (frames[c].phase == PH_SKIP && is_space) return;
		if (frames[c].phase == PH_SKIP && (b == "+" || b == "-")) begin
			frames[c].negative = (b == "-");
			frames[c].phase = PH_SIGN;
			return;
		end
		case (frames[c].phase)
			PH_SKIP, PH_SIGN: begin
				if (is_digit) begin
					frames[c].value = LENGTH_BITS'(b - 8'd48);
					frames[c].phase = PH_DIGITS;
				end else begin
					frames[c].value = '0;
					frames[c].negative = 1'b0;
					frames[c].phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (!is_digit) begin
					frames[c].phase = PH_DONE;
				end else if (grown > {4'd0, {LENGTH_BITS{1'b1}}}) begin
					frames[c].value = '1;
					frames[c].negative = 1'b0;
					frames[c].phase = PH_DONE;
				end else begin
					frames[c].value = grown[LENGTH_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void header_char(int c, bit [7:0] b);
		if (frames[c].line_pos < PREFIX_LEN) begin
			if (frames[c].prefix_ok &&
				b != LENGTH_PREFIX[(PREFIX_LEN - 1 - frames[c].line_pos) * 8 +: 8]) begin
				frames[c].prefix_ok = 1'b0;
			end
			frames[c].line_pos++;
		end else if (frames[c].prefix_ok) begin
			scan_length(c, b);
		end
	endfunction

	function automatic cls_t end_line(int c, output bit done);
		done = 1'b0;
		if (frames[c].line_pos == 0) begin
			if (frames[c].remaining != 0) begin
				frames[c].in_body = 1'b1;
			end else begin
				done = 1'b1;
			end
			restart_line(c);
			return CLS_BLOCK_END;
		end
		if (frames[c].prefix_ok && frames[c].line_pos >= PREFIX_LEN) begin
			frames[c].remaining = frames[c].negative ? ~frames[c].value + 1'b1 : frames[c].value;
		end
		restart_line(c);
		return CLS_LINE_END;
	endfunction

	function automatic void push_framed(int c, bit [7:0] b, cls_t cls, bit done);
		framed_item_t f;
		f.conn = CONN_W'(c);
		f.data = b;
		f.cls = cls;
		f.done = done;
		f.last = 1'b0;
		framed_q.insert(framed_q.size(), f);
	endfunction

	function automatic void frame_beat(bit kind, int c, bit [7:0] b);
		int produced;
		bit done;
		cls_t cls;
		produced = 0;
		if (c >= CONNECTIONS) return;
		if (kind) begin
			clear_conn(c);
			return;
		end
		if (frames[c].in_body) begin
			if (frames[c].remaining != 0) frames[c].remaining--;
			done = (frames[c].remaining == 0);
			if (done) frames[c].in_body = 1'b0;
			push_framed(c, b, CLS_BODY, done);
			produced = 1;
		end else if (frames[c].cr_held) begin
			if (b == CH_LF) begin
				frames[c].cr_held = 1'b0;
				cls = end_line(c, done);
				push_framed(c, 8'd0, cls, done);
				produced = 1;
			end else if (b == CH_CR) begin
				header_char(c, CH_CR);
				push_framed(c, CH_CR, CLS_LINE_BYTE, 1'b0);
				produced = 1;
			end else begin
				frames[c].cr_held = 1'b0;
				header_char(c, CH_CR);
				push_framed(c, CH_CR, CLS_LINE_BYTE, 1'b0);
				header_char(c, b);
				push_framed(c, b, CLS_LINE_BYTE, 1'b0);
				produced = 2;
			end
		end else if (b == CH_CR) begin
			frames[c].cr_held = 1'b1;
		end else begin
			header_char(c, b);
			push_framed(c, b, CLS_LINE_BYTE, 1'b0);
			produced = 1;
		end
		if (produced > 0) begin
			framed_q[framed_q.size() - 1].last = 1'b1;
		end
	endfunction

	// Stimulus generation: one stream of beats per connection, interleaved later.

	function automatic void add_char(int c, bit [7:0] b);
		streams[c].insert(streams[c].size(), {1'b0, b});
	endfunction

	function automatic void add_event(int c);
		bit [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		streams[c].insert(streams[c].size(), {1'b1, junk});
	endfunction

	function automatic void add_text(int c, string s);
		for (int i = 0; i < s.len(); i++) add_char(c, s[i]);
	endfunction

	function automatic bit [7:0] plain_char();
		bit [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_LF || b == CH_CR) b = b + 8'h80;
		return b;
	endfunction

	function automatic void end_of_line(int c);
		add_char(c, CH_CR);
		add_char(c, CH_LF);
	endfunction

	function automatic void add_header_line(int c);
		int n;
		case ($urandom_range(0, 3))
			0: add_text(c, "GET /index.html HTTP/1.1");
			1: add_text(c, "Host: node7");
			default: begin
				n = $urandom_range(1, 14);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 9))
						0: add_char(c, CH_LF);
						1: begin
							repeat ($urandom_range(1, 2)) add_char(c, CH_CR);
							add_char(c, plain_char());
						end
						default: add_char(c, plain_char());
					endcase
				end
			end
		endcase
	endfunction

	function automatic void add_length_line(int c, inout int blen, inout bit huge);
		int n;
		n = $urandom_range(0, 40);
		case ($urandom_range(0, 15))
			0: add_text(c, "content-length: 9");
			1: add_text(c, "Content-Length:9");
			default: begin
				add_text(c, "Content-Length: ");
				case ($urandom_range(0, 14))
					0, 1, 2: begin
						add_text(c, $sformatf("%0d", n));
						blen = n;
						huge = 1'b0;
					end
					3: begin
						add_char(c, " ");
						add_char(c, 8'd9);
						add_char(c, 8'd11);
						add_char(c, 8'd12);
						add_char(c, CH_LF);
						add_char(c, CH_CR);
						add_char(c, " ");
						add_text(c, $sformatf("+%0d", n));
						blen = n;
						huge = 1'b0;
					end
					4: begin
						add_text(c, "-0");
						blen = 0;
						huge = 1'b0;
					end
					5: begin
						add_text(c, "-4294967295");
						blen = 1;
						huge = 1'b0;
					end
					6: begin
						add_text(c, "-4294967290xyz");
						blen = 6;
						huge = 1'b0;
					end
					7: begin
						add_text(c, "4294967295");
						huge = 1'b1;
					end
					8: begin
						add_text(c, "4294967296");
						huge = 1'b1;
					end
					9: begin
						add_text(c, "-99999999999999");
						huge = 1'b1;
					end
					10: begin
						add_text(c, "-1");
						huge = 1'b1;
					end
					11: begin
						add_text(c, "abc12");
						blen = 0;
						huge = 1'b0;
					end
					12: begin
						add_text(c, ($urandom_range(0, 1) == 0) ? "-" : "+ 5");
						blen = 0;
						huge = 1'b0;
					end
					13: begin
						add_text(c, $sformatf("000%0d;q=1", n));
						blen = n;
						huge = 1'b0;
					end
					default: begin
						blen = 0;
						huge = 1'b0;
					end
				endcase
			end
		endcase
	endfunction

	function automatic void add_request(int c);
		int blen;
		bit huge;
		int lines;
		blen = 0;
		huge = 1'b0;
		lines = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0) add_event(c);
		for (int i = 0; i < lines; i++) begin
			if ($urandom_range(0, 1) == 0) add_length_line(c, blen, huge);
			else add_header_line(c);
			end_of_line(c);
		end
		end_of_line(c);
		if (huge) begin
			repeat ($urandom_range(1, 6)) add_char(c, 8'($urandom_range(0, 255)));
			add_event(c);
		end else begin
			repeat (blen) add_char(c, 8'($urandom_range(0, 255)));
		end
		requests_built++;
	endfunction

	function automatic void add_noise(int c);
		repeat ($urandom_range(4, 20)) begin
			if ($urandom_range(0, 7) == 0) add_event(c);
			else add_char(c, 8'($urandom_range(0, 255)));
		end
		add_event(c);
	endfunction

	function automatic void add_broken(int c);
		if ($urandom_range(0, 1) == 0) begin
			add_header_line(c);
			add_char(c, CH_CR);
		end else begin
			add_text(c, "Content-Length: 12");
			end_of_line(c);
			end_of_line(c);
			repeat ($urandom_range(1, 5)) add_char(c, 8'($urandom_range(0, 255)));
		end
		add_event(c);
	endfunction

	function automatic void push_beat(bit kind, int c, bit [7:0] b);
		rx_beat_t t;
		t.pause = 1'b0;
		t.kind = kind;
		t.conn = CONN_W'(c);
		t.data = b;
		t.chunk_last = ($urandom_range(0, 3) == 0);
		stim_q.insert(stim_q.size(), t);
	endfunction

	function automatic void push_pause();
		rx_beat_t t;
		t = '0;
		t.pause = 1'b1;
		stim_q.insert(stim_q.size(), t);
	endfunction

	// Driver: bursts of beats with random gaps; a pause entry holds off until
	// all predicted items have arrived.
	always @(posedge clk or negedge arst_n) begin
		rx_beat_t nxt;
		bit drive;
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.kind <= 1'b0;
			rx_if.connection <= '0;
			rx_if.data_byte <= 8'd0;
			rx_if.chunk_last <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				frame_beat(rx_if.kind, int'(rx_if.connection), rx_if.data_byte);
				beats_taken++;
				if (rx_if.kind) events_taken++;
			end
			if (!rx_if.valid || rx_if.ready) begin
				drive = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() != 0 && stim_q[0].pause) begin
					if (framed_q.size() == 0) begin
						stim_q.delete(0);
						pauses_done++;
					end
				end else if (stim_q.size() != 0) begin
					nxt = stim_q.pop_front();
					drive = 1'b1;
					rx_if.kind <= nxt.kind;
					rx_if.connection <= nxt.conn;
					rx_if.data_byte <= nxt.data;
					rx_if.chunk_last <= nxt.chunk_last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
						gap_left = $urandom_range(0, 6);
					end
				end
				rx_if.valid <= drive;
			end
		end
	end

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Monitor and receiver stall pattern.
	always @(posedge clk or negedge arst_n) begin
		framed_item_t want;
		bit rdy;
		if (!arst_n) begin
			tx_if.ready <= 1'b0;
			ready_left = 0;
		end else begin
			if (tx_if.valid && tx_if.ready) begin
				if (framed_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, actual conn %0d byte %0h class %0d",
						$time, tx_if.connection_out, tx_if.byte_out, tx_if.item_class);
				end else begin
					want = framed_q.pop_front();
					compare_field("connection_out", want.conn, tx_if.connection_out);
					compare_field("byte_out", want.data, tx_if.byte_out);
					compare_field("item_class", want.cls, tx_if.item_class);
					compare_field("request_done", want.done, tx_if.request_done);
					compare_field("last", want.last, tx_if.last);
					seen_cls[want.cls]++;
					if (want.done) done_count++;
				end
			end
			rdy = tx_if.ready;
			if (ready_left == 0) begin
				rdy = !rdy;
				if (rdy) begin
					ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
						: $urandom_range(1, 10);
				end else begin
					ready_left = $urandom_range(0, 4);
				end
			end else begin
				ready_left--;
			end
			tx_if.ready <= rdy;
		end
	end

	initial begin : stimulus
		int c;
		int total;
		int size0;
		int run;
		int left;
		bit [8:0] e;
		arst_n = 1'b0;
		for (int i = 0; i < CONNECTIONS; i++) clear_conn(i);

		push_beat(1'b1, 7, 8'hFF);
		push_beat(1'b0, 0, 8'h00);
		push_beat(1'b0, 0, 8'hFF);
		push_beat(1'b0, 0, CH_CR);
		push_beat(1'b0, 0, CH_CR);
		push_beat(1'b0, 0, "A");
		push_beat(1'b0, 0, CH_LF);
		push_beat(1'b0, 0, CH_CR);
		push_beat(1'b0, 0, CH_LF);
		push_beat(1'b0, 0, CH_CR);
		push_beat(1'b0, 0, CH_LF);
		push_beat(1'b0, 7, CH_CR);
		push_beat(1'b0, 7, CH_LF);
		push_beat(1'b0, 4, "z");
		push_beat(1'b0, 4, CH_CR);
		push_beat(1'b1, 4, 8'h00);
		push_beat(1'b0, 4, "q");
		push_beat(1'b1, 0, 8'h5A);
		push_pause();

		total = 0;
		while (total < 800) begin
			c = $urandom_range(0, CONNECTIONS - 1);
			size0 = streams[c].size();
			case ($urandom_range(0, 9))
				0: add_noise(c);
				1: add_broken(c);
				default: add_request(c);
			endcase
			total += streams[c].size() - size0;
		end
		left = total;
		while (left > 0) begin
			do c = $urandom_range(0, CONNECTIONS - 1); while (streams[c].size() == 0);
			run = $urandom_range(1, 8);
			while (run > 0 && streams[c].size() != 0) begin
				e = streams[c].pop_front();
				push_beat(e[8], c, e[7:0]);
				run--;
				left--;
			end
			if ($urandom_range(0, 149) == 0) push_pause();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (stim_q.size() != 0 || rx_if.valid);
		while (framed_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Run took %0d beats (%0d open or close events) in %0d built requests, %0d drains.",
			beats_taken, events_taken, requests_built, pauses_done);
		$display("Items checked: %0d line bytes, %0d line ends, %0d header ends, %0d body, %0d done.",
			seen_cls[CLS_LINE_BYTE], seen_cls[CLS_LINE_END], seen_cls[CLS_BLOCK_END],
			seen_cls[CLS_BODY], done_count);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hrf_pkg.sv
rtl/hrf_in_if.sv
rtl/hrf_out_if.sv
rtl/http_request_framer.sv
tb/http_request_framer_tb.sv
